### hw/rtl/assert_macros.svh
// Assertion macros for the checker file tppm_checker.sv.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tppm_pkg.sv
// Shared types and constants of the ternary pattern priority match unit.
// No dependencies; imported by tppm_align, tppm_mem, the top module and the testbench.
package tppm_pkg;

   localparam int KEY_BITS = 128;
   localparam logic [7:0] MAX_KEY_BITS = 8'd128;
   localparam logic [7:0] MATCH_WIDTH_RESET = 8'd128;

   // transaction codes
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // one stored table word
   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] value;
      logic [KEY_BITS-1:0] care;
   } entry_type;

endpackage

### hw/rtl/tppm_align.sv
// Pattern alignment for table writes: trims to pattern width, aligns to the top of the
// match width, masks the value and flags patterns wider than the match width. Depends on tppm_pkg.
module tppm_align (
   input  logic [7:0]                   match_width,
   input  logic [7:0]                   pattern_width,
   input  logic [tppm_pkg::KEY_BITS-1:0] value,
   input  logic [tppm_pkg::KEY_BITS-1:0] care,
   output tppm_pkg::entry_type          entry,
   output logic                         width_error
);
   import tppm_pkg::*;

   logic [7:0]          mw;
   logic [7:0]          shift;
   logic [KEY_BITS-1:0] trim_mask;
   logic [KEY_BITS-1:0] care_al;
   logic [KEY_BITS-1:0] value_al;

   always_comb begin
      mw = (match_width > MAX_KEY_BITS) ? MAX_KEY_BITS : match_width;
      width_error = pattern_width > mw;
      shift = mw - pattern_width;
      // shifts of KEY_BITS or more give zero, so widths >= 128 keep everything
      trim_mask = ~({KEY_BITS{1'b1}} << pattern_width);
      care_al  = (care & trim_mask) << shift;
      value_al = (value & trim_mask) << shift;
      entry.valid = 1'b1;
      entry.care  = care_al;
      entry.value = value_al & care_al;
   end

endmodule

### hw/rtl/tppm_mem.sv
// Pattern table storage: one write port, one read port, registered read.
// Depends on tppm_pkg for the entry word layout.
module tppm_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tppm_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output tppm_pkg::entry_type rd_data
);
   import tppm_pkg::*;

   entry_type mem_q [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ternary_pattern_priority_match_unit.sv
// Ternary pattern table with lowest-index priority match.
// Input channel req_*: valid/ready. req_type selects a table write (pattern, care mask,
//   width, valid flag at req_entry_index) or a lookup of the 128-bit key.
// Output channel rsp_*: valid/ready, one transaction per request: match flag and
//   index for lookups, write_error for valid-entry stores wider than the match width.
// csr_write_en/csr_write_data set match_width; write it only while the block is idle.
// One request is worked on at a time. A write passes through the WRITE and RESP states
// before rsp_valid rises. A lookup scans the table memory one entry per cycle through
// its single read port and stops at the first hit or after the last entry. The block
// goes back to idle, ready for the next request, as the response is loaded into the
// output register, even if it has not been taken yet.
// After reset a clearing pass writes every table entry invalid, during which req_ready
// is low. match_width resets to 128.
// When the receiver stalls, a finished response waits in the output register and
// the next request may still be accepted; its response waits until the slot frees.
module ternary_pattern_priority_match_unit #(
   parameter int ENTRY_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [5:0]  req_entry_index,
   input  logic        req_entry_valid,
   input  logic [7:0]  req_pattern_width,
   input  logic [63:0] req_value_high,
   input  logic [63:0] req_value_low,
   input  logic [63:0] req_care_high,
   input  logic [63:0] req_care_low,
   input  logic [63:0] req_key_high,
   input  logic [63:0] req_key_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_match_found,
   output logic [5:0]  rsp_match_index,
   output logic        rsp_write_error,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);
   import tppm_pkg::*;

   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRY_COUNT - 1);
   localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(ENTRY_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [7:0]          match_width_ff;

   logic [5:0]          idx_ff;
   logic                ev_ff;
   logic [7:0]          pw_ff;
   logic [KEY_BITS-1:0] value_ff, care_ff, key_ff;

   logic                res_found_ff, res_found_in;
   logic [5:0]          res_idx_ff, res_idx_in;
   logic                res_err_ff, res_err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [5:0]          rsp_idx_ff, rsp_idx_in;
   logic                rsp_err_ff, rsp_err_in;

   entry_type           align_entry;
   logic                align_err;
   logic                in_range;
   logic                hit;
   logic                mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   entry_type           mem_wr_data, mem_rd_data;

   tppm_align u_align (
      .match_width   (match_width_ff),
      .pattern_width (pw_ff),
      .value         (value_ff),
      .care          (care_ff),
      .entry         (align_entry),
      .width_error   (align_err)
   );

   tppm_mem #(
      .DEPTH (ENTRY_COUNT),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign in_range  = 32'(idx_ff) < ENTRY_COUNT;
   assign hit = mem_rd_data.valid && ((key_ff & mem_rd_data.care) == mem_rd_data.value);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = addr_ff[IDX_W-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = IDX_W'(idx_ff);
      mem_wr_data  = align_entry;
      mem_rd_en    = 1'b0;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_ff[IDX_W-1:0];
            mem_wr_data = '0;
            if (addr_ff == LAST_CNT) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               addr_in  = '0;
               state_in = (req_type == REQ_WRITE) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_WRITE: begin
            // invalidation writes a cleared word; a refused store leaves the entry alone
            mem_wr_en    = in_range && !(ev_ff && align_err);
            mem_wr_data  = ev_ff ? align_entry : '0;
            res_found_in = 1'b0;
            res_idx_in   = '0;
            res_err_in   = in_range && ev_ff && align_err;
            state_in     = ST_RESP;
         end
         ST_SCAN: begin
            if (addr_ff != END_CNT) begin
               mem_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               addr_in   = addr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (hit) begin
                  res_found_in = 1'b1;
                  res_idx_in   = 6'(rd_idx_ff);
                  res_err_in   = 1'b0;
                  state_in     = ST_RESP;
               end else if (rd_idx_ff == LAST_IDX) begin
                  res_found_in = 1'b0;
                  res_idx_in   = '0;
                  res_err_in   = 1'b0;
                  state_in     = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         addr_ff        <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         match_width_ff <= MATCH_WIDTH_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            match_width_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      res_err_ff   <= res_err_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_err_ff   <= rsp_err_in;
      if (req_valid && req_ready) begin
         idx_ff   <= req_entry_index;
         ev_ff    <= req_entry_valid;
         pw_ff    <= req_pattern_width;
         value_ff <= {req_value_high, req_value_low};
         care_ff  <= {req_care_high, req_care_low};
         key_ff   <= {req_key_high, req_key_low};
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_write_error = rsp_err_ff;

endmodule

### hw/rtl/tppm_checker.sv
// Port-level checks for the ternary pattern priority match unit, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tppm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_match_found,
   input logic [5:0] rsp_match_index,
   input logic       rsp_write_error
);

   // a stalled response keeps its payload
   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_found) && $stable(rsp_match_index) && $stable(rsp_write_error), "response changed while stalled")

   // a write error never comes with a match
   `ASSERT_CLKD(a_err_no_match, clock, reset, rsp_valid && rsp_write_error |-> !rsp_match_found, "write error reported with a match")

   // no match reports index zero
   `ASSERT_CLKD(a_miss_index, clock, reset, rsp_valid && !rsp_match_found |-> rsp_match_index == 6'd0, "nonzero index without a match")

   // reset empties the output register
   `ASSERT_ALWAYS(a_reset_rsp, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind ternary_pattern_priority_match_unit tppm_checker u_tppm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_match_found (rsp_match_found),
   .rsp_match_index (rsp_match_index),
   .rsp_write_error (rsp_write_error)
);

### test/ternary_pattern_priority_match_unit_tb.sv
// Self-checking testbench for ternary_pattern_priority_match_unit.
// Uses tppm_pkg; holds its own model of the pattern table and checks every response.
// Stimulus: a directed table first, then random write and lookup traffic over several widths.
module ternary_pattern_priority_match_unit_tb;
   import tppm_pkg::*;

   localparam int          TABLE_SIZE    = 64;
   localparam int          IDLE_PCT      = 33;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          STALL_LIMIT   = 3000;
   localparam int          PHASE_COUNT   = 13;
   localparam int          PHASE_ITEMS   = 150;
   localparam logic [63:0] ONES          = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic        req_type;
      logic [5:0]  entry_index;
      logic        entry_valid;
      logic [7:0]  pattern_width;
      logic [63:0] value_high;
      logic [63:0] value_low;
      logic [63:0] care_high;
      logic [63:0] care_low;
      logic [63:0] key_high;
      logic [63:0] key_low;
   } request_type;

   typedef struct {
      logic       match_found;
      logic [5:0] match_index;
      logic       write_error;
   } response_type;

   typedef struct {
      logic [7:0]   width;
      request_type  req;
      bit           typed;
      response_type rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_WRITE;
   logic [5:0]  req_entry_index = '0;
   logic        req_entry_valid = 1'b0;
   logic [7:0]  req_pattern_width = '0;
   logic [63:0] req_value_high = '0;
   logic [63:0] req_value_low = '0;
   logic [63:0] req_care_high = '0;
   logic [63:0] req_care_low = '0;
   logic [63:0] req_key_high = '0;
   logic [63:0] req_key_low = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_match_found;
   logic [5:0]  rsp_match_index;
   logic        rsp_write_error;
   logic        csr_write_en = 1'b0;
   logic [7:0]  csr_write_data = '0;

   // model of the pattern table
   logic [KEY_BITS-1:0] tbl_value [TABLE_SIZE];
   logic [KEY_BITS-1:0] tbl_care  [TABLE_SIZE];
   bit                  tbl_valid [TABLE_SIZE];
   logic [7:0]          width_setting = MATCH_WIDTH_RESET;

   response_type     expected_responses [$];
   directed_row_type directed_rows [$];
   int unsigned      error_count = 0;
   int unsigned      quiet_cycles = 0;
   bit               calm_stretch = 1'b0;
   int unsigned      hold_requests = 0;
   logic [7:0]       phase_width [PHASE_COUNT];

   ternary_pattern_priority_match_unit #(
      .ENTRY_COUNT(TABLE_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_entry_index(req_entry_index),
      .req_entry_valid(req_entry_valid),
      .req_pattern_width(req_pattern_width),
      .req_value_high(req_value_high),
      .req_value_low(req_value_low),
      .req_care_high(req_care_high),
      .req_care_low(req_care_low),
      .req_key_high(req_key_high),
      .req_key_low(req_key_low),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_match_found(rsp_match_found),
      .rsp_match_index(rsp_match_index),
      .rsp_write_error(rsp_write_error),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Updates the table model for one transaction and returns its response.
   function automatic response_type predict_response(input request_type r);
      response_type        res;
      int unsigned         mw;
      int unsigned         pw;
      logic [KEY_BITS-1:0] keep;
      logic [KEY_BITS-1:0] v;
      logic [KEY_BITS-1:0] c;
      logic [KEY_BITS-1:0] key;
      res = '{1'b0, 6'd0, 1'b0};
      mw = (width_setting > MAX_KEY_BITS) ? 32'(MAX_KEY_BITS) : 32'(width_setting);
      pw = 32'(r.pattern_width);
      if (r.req_type == REQ_WRITE) begin
         if (!r.entry_valid) begin
            tbl_valid[r.entry_index] = 1'b0;
         end else if (pw > mw) begin
            res.write_error = 1'b1;
         end else begin
            keep = (pw >= KEY_BITS) ? '1 : ((128'd1 << pw) - 128'd1);
            v = {r.value_high, r.value_low} & keep;
            c = {r.care_high, r.care_low} & keep;
            v = v << (mw - pw);
            c = c << (mw - pw);
            tbl_value[r.entry_index] = v & c;
            tbl_care[r.entry_index]  = c;
            tbl_valid[r.entry_index] = 1'b1;
         end
      end else begin
         key = {r.key_high, r.key_low};
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!res.match_found && tbl_valid[i] && (key & tbl_care[i]) == tbl_value[i]) begin
               res.match_found = 1'b1;
               res.match_index = i[5:0];
            end
         end
      end
      return res;
   endfunction

   function automatic request_type noise_request();
      request_type r;
      r.req_type      = 1'($urandom_range(0, 1));
      r.entry_index   = 6'($urandom_range(0, TABLE_SIZE - 1));
      r.entry_valid   = 1'($urandom_range(0, 1));
      r.pattern_width = 8'($urandom_range(1, KEY_BITS));
      r.value_high    = rand64();
      r.value_low     = rand64();
      r.care_high     = rand64();
      r.care_low      = rand64();
      r.key_high      = rand64();
      r.key_low       = rand64();
      return r;
   endfunction

   function automatic logic [7:0] pick_width(input int unsigned mw);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return 8'(mw);
      if (roll < 45) return 8'd1;
      if (roll < 55 && mw < KEY_BITS) return 8'($urandom_range(mw + 1, KEY_BITS));
      if (roll < 58) return 8'(KEY_BITS);
      return 8'($urandom_range(1, mw));
   endfunction

   function automatic request_type make_write(input int unsigned mw);
      request_type r;
      r = noise_request();
      r.req_type = REQ_WRITE;
      // low slots get rewritten often so lookups see overlapping priorities
      r.entry_index = ($urandom_range(0, 99) < 60) ? 6'($urandom_range(0, 15))
                                                   : 6'($urandom_range(0, TABLE_SIZE - 1));
      r.entry_valid   = ($urandom_range(0, 99) >= 10);
      r.pattern_width = pick_width(mw);
      case ($urandom_range(0, 2))
         0: begin
            r.care_high = rand64() & rand64() & rand64();
            r.care_low  = rand64() & rand64() & rand64();
         end
         1: begin
            r.care_high = rand64() | rand64();
            r.care_low  = rand64() | rand64();
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic request_type make_lookup();
      request_type         r;
      int unsigned         live [$];
      int unsigned         pick;
      logic [KEY_BITS-1:0] key;
      r = noise_request();
      r.req_type = REQ_LOOKUP;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (tbl_valid[i]) live.push_back(i);
      end
      key = {rand64(), rand64()};
      if (live.size() != 0 && $urandom_range(0, 99) < 70) begin
         // key built to hit a live entry, sometimes with one bit flipped; lower entries may still win
         pick = live[$urandom_range(0, live.size() - 1)];
         key = (key & ~tbl_care[pick]) | tbl_value[pick];
         if ($urandom_range(0, 99) < 15) key[$urandom_range(0, KEY_BITS - 1)] ^= 1'b1;
      end
      {r.key_high, r.key_low} = key;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] w, input logic t, input logic [5:0] idx,
                          input logic ev, input logic [7:0] pw,
                          input logic [63:0] vh, input logic [63:0] vl,
                          input logic [63:0] ch, input logic [63:0] cl,
                          input logic [63:0] kh, input logic [63:0] kl,
                          input bit typed, input logic f, input logic [5:0] mi,
                          input logic we);
      directed_row_type row;
      row.width = w;
      row.req   = '{t, idx, ev, pw, vh, vl, ch, cl, kh, kl};
      row.typed = typed;
      row.rsp   = '{f, mi, we};
      directed_rows.push_back(row);
   endtask

   // Drives one transaction from a falling edge and returns at the edge that accepts it.
   task automatic offer_request(input request_type r);
      @(negedge clock);
      while (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= r.req_type;
      req_entry_index   <= r.entry_index;
      req_entry_valid   <= r.entry_valid;
      req_pattern_width <= r.pattern_width;
      req_value_high    <= r.value_high;
      req_value_low     <= r.value_low;
      req_care_high     <= r.care_high;
      req_care_low      <= r.care_low;
      req_key_high      <= r.key_high;
      req_key_low       <= r.key_low;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   // Register write only once the block has gone idle.
   task automatic apply_match_width(input logic [7:0] w);
      drain_responses();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= w;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      width_setting = w;
   endtask

   // receiver side
   initial begin
      int unsigned holds_done;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp_ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      response_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $error("response transaction with no request pending");
            error_count++;
         end else begin
            exp_rsp = expected_responses.pop_front();
            if (rsp_match_found !== exp_rsp.match_found) begin
               $error("match_found: expected %0d, got %0d", exp_rsp.match_found,
                      rsp_match_found);
               error_count++;
            end
            if (rsp_match_index !== exp_rsp.match_index) begin
               $error("match_index: expected %0d, got %0d", exp_rsp.match_index,
                      rsp_match_index);
               error_count++;
            end
            if (rsp_write_error !== exp_rsp.write_error) begin
               $error("write_error: expected %0d, got %0d", exp_rsp.write_error,
                      rsp_write_error);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      request_type  r;
      response_type predicted;
      for (int i = 0; i < TABLE_SIZE; i++) tbl_valid[i] = 1'b0;
      phase_width = '{8'd128, 8'd1, 8'd64, 8'd65, 8'd127, 8'd2, 8'd63,
                      8'd100, 8'd128, 8'd8, 8'd33, 8'd96, 8'd128};

      // empty table, full words, all-don't-care entry, invalidation
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, ONES, ONES, 1, 0, 0, 0);
      add_row(128, REQ_WRITE, 0, 1, 128, ONES, ONES, ONES, ONES, 0, 0, 1, 0, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, ONES, ONES, 1, 1, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, ONES, ONES - 1, 0, 0, 0, 0);
      add_row(128, REQ_WRITE, 63, 1, 0, ONES, ONES, ONES, ONES, 0, 0, 1, 0, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 63, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 64'h1234_5678_9ABC_DEF0,
              64'h0F1E_2D3C_4B5A_6978, 1, 1, 63, 0);
      add_row(128, REQ_WRITE, 0, 0, 128, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, ONES, ONES, 1, 1, 63, 0);
      add_row(128, REQ_WRITE, 63, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, ONES, ONES, 1, 0, 0, 0);
      // one-bit key: too-wide store refused, invalidation ignores the width
      add_row(1, REQ_WRITE, 5, 1, 2, 0, 3, 0, 3, 0, 0, 1, 0, 0, 1);
      add_row(1, REQ_WRITE, 5, 0, 128, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(1, REQ_WRITE, 5, 1, 1, ONES, ONES, ONES, ONES, 0, 0, 1, 0, 0, 0);
      add_row(1, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 5, 0);
      add_row(1, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, ONES, 0, 0, 0, 0, 0);
      // short pattern lands in the top byte; bits above its width dropped
      add_row(128, REQ_WRITE, 7, 1, 8, ONES, 64'hFFFF_FFFF_FFFF_FFAB, ONES,
              64'h00FF_FF00_0000_00FF, 0, 0, 1, 0, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 64'hAB12_3456_789A_BCDE, 0,
              0, 0, 0, 0);
      // value not a subset of the care mask
      add_row(128, REQ_WRITE, 1, 1, 64, ONES, 64'hF0F0_1234_5678_9ABC, 0,
              64'h0FF0_FFFF_0000_FFFF, 0, 0, 1, 0, 0, 0);
      add_row(128, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 64'h50F0_5678_AAAA_9ABC, ONES,
              0, 0, 0, 0);
      add_row(64, REQ_WRITE, 2, 1, 64, 0, 64'hDEAD_BEEF_0000_0001, 0, ONES, 0, 0,
              1, 0, 0, 0);
      add_row(64, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, ONES, 64'hDEAD_BEEF_0000_0001,
              0, 0, 0, 0);
      // pattern straddling the 64-bit boundary
      add_row(65, REQ_WRITE, 3, 1, 65, 1, 0, 1, ONES, 0, 0, 1, 0, 0, 0);
      add_row(65, REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].width != width_setting) apply_match_width(directed_rows[n].width);
         offer_request(directed_rows[n].req);
         predicted = predict_response(directed_rows[n].req);
         expected_responses.push_back(directed_rows[n].typed ? directed_rows[n].rsp : predicted);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (phase_width[p] != width_setting) apply_match_width(phase_width[p]);
         calm_stretch = (p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver stall while requests keep coming
            if (p == 7 && n == 50) hold_requests++;
            r = ($urandom_range(0, 99) < 45) ? make_write(32'(width_setting)) : make_lookup();
            offer_request(r);
            expected_responses.push_back(predict_response(r));
         end
      end
      calm_stretch = 1'b0;

      drain_responses();
      repeat (TABLE_SIZE + 8) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
